// File: sv/stt_pkg.sv
// Shared types and constants of the software timer table engine.
package stt_pkg;

  localparam int NumSlots     = 32;
  localparam int SlotW        = $clog2(NumSlots);
  localparam int IdxW         = $clog2(NumSlots + 1);
  localparam int WordW        = 32;
  localparam int TaskW        = 4;
  localparam int GenW         = 24;
  localparam int SlotByteW    = 8;
  localparam int KindW        = 2;
  localparam int TickLenW     = 16;
  localparam logic [TickLenW-1:0] TickLenReset = 16'd10;

  // divider: 33-bit rounded numerator, one quotient bit per step
  localparam int DivNumW      = WordW + 1;
  localparam int DivSteps     = DivNumW;
  localparam int DivCntW      = $clog2(DivSteps);

  localparam int InFieldsW    = TaskW + 3 * WordW;
  localparam int InDataW      = ((InFieldsW + 7) / 8) * 8;
  localparam int OutFieldsW   = WordW + TaskW + WordW;
  localparam int OutDataW     = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [KindW-1:0] KindOneShot  = 2'd0;
  localparam logic [KindW-1:0] KindPeriodic = 2'd1;
  localparam logic [KindW-1:0] KindCancel   = 2'd2;
  localparam logic [KindW-1:0] KindTick     = 2'd3;

  localparam logic ResStart  = 1'b0;
  localparam logic ResExpiry = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_START_WR,
    ST_REPLY,
    ST_CANCEL,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [WordW-1:0] expiry;
    logic [WordW-1:0] period;
    logic [GenW-1:0]  gen;
    logic [TaskW-1:0] task_id;
    logic [WordW-1:0] msg;
  } slot_t;

endpackage

// File: sv/stt_div.sv
// Restoring divider, one quotient bit per cycle, for rounding delays to ticks.
module stt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [stt_pkg::DivNumW-1:0]   numer_i,
  input  logic [stt_pkg::TickLenW-1:0]  denom_i,
  output logic                          done_o,
  output logic [stt_pkg::WordW-1:0]     quot_o
);
  import stt_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [DivNumW-1:0]  num_q;
  logic [TickLenW-1:0] rem_q;
  logic [TickLenW-1:0] den_q;

  logic [TickLenW:0]   rem_sh;
  logic                ge;
  logic [TickLenW:0]   rem_sub;

  assign rem_sh  = {rem_q, num_q[DivNumW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where numerator bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= numer_i;
      rem_q <= '0;
      den_q <= denom_i;
    end else if (busy_q) begin
      num_q <= {num_q[DivNumW-2:0], ge};
      rem_q <= ge ? rem_sub[TickLenW-1:0] : rem_sh[TickLenW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q[WordW-1:0];

endmodule

// File: sv/software_timer_table_engine.sv
// Top level of the software timer table engine: command FSM, slot memory, result output.
//
// Input channel s_axis: one command word per handshake; tuser carries the kind
// (start one-shot, start periodic, cancel, tick), tdata the task, message,
// delay and cancel id. Output channel m_axis: result words; tuser 0 marks a
// start reply (timer id, 0 when the table is full), 1 an expiry message;
// tlast is set on the final word caused by one command. cfg_we_i writes the
// tick length in ms (reset 10, 0 acts as 1).
// Slot state lives in one 32-entry memory with registered read; active and
// written flags per slot sit in flip-flops, so reset clears the table at once.
// Commands are taken one at a time. With a ready receiver a start gives its
// reply after 33 steps of the restoring divider that rounds the delay to ticks;
// the engine then sees it done, writes the slot and loads the reply, and the
// next command is taken the cycle after. A start into a full table goes
// straight to the reply state. A tick scans with one memory read per slot,
// pipelined so a slot is checked while the next is read; its last word is loaded
// at the end of the scan and the next command is taken the cycle after. A cancel
// passes through the cancel state (it stays idle when the id names no slot) and
// gives no word. A new command is accepted while the last word still waits in
// the output register. When the receiver stalls, the scan holds with one due
// word pending behind the output register.
module software_timer_table_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stt_pkg::TickLenW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // task_id[3:0], message[35:4], delay_ms[67:36], cancel_id[99:68], zero pad
  input  logic [stt_pkg::InDataW-1:0]   s_axis_tdata,
  // kind[1:0]
  input  logic [stt_pkg::KindW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // timer_id[31:0], target_task[35:32], payload[67:36], zero pad
  output logic [stt_pkg::OutDataW-1:0]  m_axis_tdata,
  // result_kind
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);
  import stt_pkg::*;

  state_e state_q, state_d;

  logic [TickLenW-1:0]  tick_len_q;
  logic [WordW-1:0]     tick_cnt_q;
  logic [NumSlots-1:0]  active_q;
  logic [NumSlots-1:0]  written_q;

  logic                 cmd_periodic_q;
  logic [TaskW-1:0]     cmd_task_q;
  logic [WordW-1:0]     cmd_msg_q;
  logic [GenW-1:0]      cmd_gen_q;
  logic [SlotW-1:0]     slot_q;
  logic [WordW-1:0]     id_q;

  logic [IdxW-1:0]      rd_idx_q;
  logic                 ev_valid_q;
  logic [SlotW-1:0]     ev_idx_q;

  logic                 pend_valid_q;
  logic [TaskW-1:0]     pend_task_q;
  logic [WordW-1:0]     pend_msg_q;

  logic                 out_valid_q;
  logic                 out_kind_q;
  logic [WordW-1:0]     out_id_q;
  logic [TaskW-1:0]     out_task_q;
  logic [WordW-1:0]     out_pay_q;
  logic                 out_last_q;

  slot_t                slot_mem [NumSlots];
  slot_t                mem_rdata_q;
  logic                 mem_re;
  logic [SlotW-1:0]     mem_raddr;
  logic                 mem_we;
  logic [SlotW-1:0]     mem_waddr;
  slot_t                mem_wdata;

  logic                 div_start;
  logic                 div_done;
  logic [WordW-1:0]     div_quot;
  logic [TickLenW-1:0]  divisor;
  logic [DivNumW-1:0]   div_numer;

  logic [KindW-1:0]     in_kind;
  logic [TaskW-1:0]     in_task;
  logic [WordW-1:0]     in_msg;
  logic [WordW-1:0]     in_delay;
  logic [WordW-1:0]     in_cid;
  logic                 in_acc;
  logic                 is_start;
  logic                 is_cancel;
  logic [SlotByteW-1:0] cid_byte;
  logic                 cancel_ok;
  logic [SlotW-1:0]     cancel_idx;

  logic                 free_any;
  logic [SlotW-1:0]     free_idx;

  logic [GenW-1:0]      gen_rd;
  logic [GenW-1:0]      new_gen;
  logic [WordW-1:0]     new_expiry;
  slot_t                new_slot;

  logic                 out_free;
  logic                 out_load;
  logic                 ev_due;
  logic                 scan_stall;
  logic                 scan_end;
  logic [WordW-1:0]     rearm_sum;
  logic                 keep_active;

  // ---- input unpacking ----
  assign in_kind  = s_axis_tuser;
  assign in_task  = s_axis_tdata[TaskW-1:0];
  assign in_msg   = s_axis_tdata[TaskW +: WordW];
  assign in_delay = s_axis_tdata[TaskW + WordW +: WordW];
  assign in_cid   = s_axis_tdata[TaskW + 2 * WordW +: WordW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_start      = (in_kind == KindOneShot) || (in_kind == KindPeriodic);
  assign is_cancel     = (in_kind == KindCancel);

  assign cid_byte   = in_cid[SlotByteW-1:0];
  assign cancel_ok  = (cid_byte != '0) && (cid_byte <= SlotByteW'(NumSlots));
  assign cancel_idx = SlotW'(cid_byte - SlotByteW'(1));

  // first inactive slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_any = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  // ---- divider ----
  assign divisor   = (tick_len_q == '0) ? TickLenW'(1) : tick_len_q;
  assign div_numer = {1'b0, in_delay} + DivNumW'(divisor >> 1);

  stt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (div_numer),
    .denom_i (divisor),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---- slot update terms ----
  assign gen_rd     = written_q[slot_q] ? mem_rdata_q.gen : '0;
  assign new_gen    = gen_rd + GenW'(1);
  assign new_expiry = tick_cnt_q + div_quot;

  always_comb begin
    new_slot.expiry  = new_expiry;
    new_slot.period  = cmd_periodic_q ? div_quot : '0;
    new_slot.gen     = new_gen;
    new_slot.task_id = cmd_task_q;
    new_slot.msg     = cmd_msg_q;
  end

  assign out_free    = !out_valid_q || m_axis_tready;
  assign ev_due      = ev_valid_q && active_q[ev_idx_q] && (tick_cnt_q >= mem_rdata_q.expiry);
  assign scan_stall  = ev_due && pend_valid_q && !out_free;
  assign scan_end    = (state_q == ST_SCAN) && !ev_valid_q && (rd_idx_q == IdxW'(NumSlots));
  assign rearm_sum   = mem_rdata_q.expiry + mem_rdata_q.period;
  assign keep_active = (mem_rdata_q.period != '0) && (rearm_sum != '0);

  // output register takes a new word
  assign out_load = ((state_q == ST_REPLY) && out_free)
                 || ((state_q == ST_SCAN) && !scan_stall && ev_due && pend_valid_q)
                 || (scan_end && pend_valid_q && out_free);

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_start) begin
            state_d = free_any ? ST_DIV : ST_REPLY;
          end else if (is_cancel) begin
            state_d = cancel_ok ? ST_CANCEL : ST_IDLE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_START_WR;
      end
      ST_START_WR: state_d = ST_REPLY;
      ST_REPLY: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_CANCEL: state_d = ST_IDLE;
      ST_SCAN: begin
        if (scan_end && (!pend_valid_q || out_free)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- memory and divider control ----
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = new_slot;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_start && free_any) begin
          mem_re    = 1'b1;
          mem_raddr = free_idx;
          div_start = 1'b1;
        end else if (in_acc && is_cancel && cancel_ok) begin
          mem_re    = 1'b1;
          mem_raddr = cancel_idx;
        end
      end
      ST_START_WR: mem_we = 1'b1;
      ST_SCAN: begin
        if (!scan_stall) begin
          if (ev_due) begin
            mem_we           = 1'b1;
            mem_waddr        = ev_idx_q;
            mem_wdata        = mem_rdata_q;
            mem_wdata.expiry = rearm_sum;
          end
          if (rd_idx_q < IdxW'(NumSlots)) begin
            mem_re    = 1'b1;
            mem_raddr = rd_idx_q[SlotW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // ---- slot memory ----
  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= slot_mem[mem_raddr];
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tick_len_q   <= TickLenReset;
      tick_cnt_q   <= '0;
      active_q     <= '0;
      written_q    <= '0;
      rd_idx_q     <= '0;
      ev_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) tick_len_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_kind == KindTick)) begin
            tick_cnt_q <= tick_cnt_q + WordW'(1);
            rd_idx_q   <= '0;
            ev_valid_q <= 1'b0;
          end
        end
        ST_START_WR: begin
          written_q[slot_q] <= 1'b1;
          active_q[slot_q]  <= (new_expiry != '0);
        end
        ST_CANCEL: begin
          if (cmd_gen_q == gen_rd) active_q[slot_q] <= 1'b0;
        end
        ST_SCAN: begin
          if (!scan_stall) begin
            if (ev_due) begin
              active_q[ev_idx_q] <= keep_active;
              pend_valid_q       <= 1'b1;
            end
            if (rd_idx_q < IdxW'(NumSlots)) begin
              ev_valid_q <= 1'b1;
              rd_idx_q   <= rd_idx_q + IdxW'(1);
            end else begin
              ev_valid_q <= 1'b0;
            end
          end
          // last due word leaves once the scan has passed every slot
          if (scan_end && pend_valid_q && out_free) begin
            pend_valid_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_periodic_q <= (in_kind == KindPeriodic);
          cmd_task_q     <= in_task;
          cmd_msg_q      <= in_msg;
          cmd_gen_q      <= in_cid[WordW-1:SlotByteW];
          slot_q         <= is_start ? free_idx : cancel_idx;
          id_q           <= '0;
        end
      end
      ST_START_WR: begin
        id_q <= {new_gen, SlotByteW'(slot_q) + SlotByteW'(1)};
      end
      ST_REPLY: begin
        if (out_free) begin
          out_kind_q <= ResStart;
          out_id_q   <= id_q;
          out_task_q <= '0;
          out_pay_q  <= '0;
          out_last_q <= 1'b1;
        end
      end
      ST_SCAN: begin
        if (!scan_stall) begin
          if (ev_due) begin
            pend_task_q <= mem_rdata_q.task_id;
            pend_msg_q  <= mem_rdata_q.msg;
            if (pend_valid_q) begin
              out_kind_q <= ResExpiry;
              out_id_q   <= '0;
              out_task_q <= pend_task_q;
              out_pay_q  <= pend_msg_q;
              out_last_q <= 1'b0;
            end
          end
          if (rd_idx_q < IdxW'(NumSlots)) ev_idx_q <= rd_idx_q[SlotW-1:0];
        end
        if (scan_end && pend_valid_q && out_free) begin
          out_kind_q <= ResExpiry;
          out_id_q   <= '0;
          out_task_q <= pend_task_q;
          out_pay_q  <= pend_msg_q;
          out_last_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---- output ----
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - OutFieldsW)'(0), out_pay_q, out_task_q, out_id_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: sv/stt_checker.sv
// Port-level checks on the result stream of the timer table engine, bound to the top level.
module stt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [stt_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);
  import stt_pkg::*;

  // a start reply is always the only word of its command
  a_reply_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ResStart)) |-> m_axis_tlast)
    else $error("start reply without tlast");

  // a granted id names a real slot
  a_reply_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ResStart) && (m_axis_tdata[WordW-1:0] != '0))
    |-> ((m_axis_tdata[SlotByteW-1:0] != '0)
         && (m_axis_tdata[SlotByteW-1:0] <= SlotByteW'(NumSlots))))
    else $error("start reply id with bad slot byte");

  // expiry words carry no timer id
  a_expiry_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ResExpiry)) |-> (m_axis_tdata[WordW-1:0] == '0))
    else $error("expiry word with nonzero timer id");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready)
    |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
    else $error("output word changed under stall");

endmodule

bind software_timer_table_engine stt_checker u_stt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
